// ===== src/pdve_pkg.sv =====
// Shared widths and digit constants for the posting delta varint encoder.
`timescale 1ns / 1ps
package pdve_pkg;
  localparam int FIELD_W = 31;
  localparam int IDX_W = 31;
  localparam int DELTA_W = IDX_W + 1;
  localparam int HEAD_DIGIT_W = 6;
  localparam int TAIL_DIGIT_W = 7;
  localparam int BYTE_W = 8;
endpackage

// ===== src/posting_delta_varint_encoder.sv =====
// Posting list encoder: document and position deltas sent as flagged varint bytes.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, doc_index_i,      | in
//           | word_position_i                           |
//   out     | out_valid_o, out_stall_i, code_byte_o,    | out
//           | last_byte_o, order_error_o                |
//
// An item enters only while the encoder is idle and leaves as one to ten output bytes;
// the next item waits on in_stall_o until this one's last byte is in the output register.
// The sequencer shifts one 6 or 7 bit digit out of sh_q per cycle unless stalled.
// Reset clears the has-doc and has-pos flags; deltas then count from minus one.
// A stall on the output holds the output register and pauses the sequencer.
`timescale 1ns / 1ps
module posting_delta_varint_encoder
  import pdve_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FIELD_W-1:0] doc_index_i,
  input  logic [FIELD_W-1:0] word_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BYTE_W-1:0]  code_byte_o,
  output logic               last_byte_o,
  output logic               order_error_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DOC  = 2'd1;
  localparam logic [1:0] ST_POS  = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic               has_doc_q, has_doc_d;
  logic               has_pos_q, has_pos_d;
  logic [IDX_W-1:0]   doc_q, doc_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [DELTA_W-1:0] sh_q, sh_d;
  logic [DELTA_W-1:0] pend_q, pend_d;
  logic               first_q, first_d;
  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic               last_q, last_d;
  logic               err_q, err_d;

  logic [IDX_W-1:0]   doc_in, pos_in;
  logic               new_doc, bad_order, accept, slot_free, more;
  logic [DELTA_W-1:0] doc_delta, pos_delta;
  logic [BYTE_W-1:0]  next_byte;

  assign doc_in = doc_index_i[IDX_W-1:0];
  assign pos_in = word_position_i[IDX_W-1:0];
  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    new_doc = !has_doc_q || (doc_in != doc_q);
    bad_order = has_doc_q && ((doc_in < doc_q) ||
                (!new_doc && has_pos_q && (pos_in < pos_q)));
    if (has_doc_q) begin
      doc_delta = {1'b0, doc_in} - {1'b0, doc_q};
    end else begin
      doc_delta = {1'b0, doc_in} + DELTA_W'(1);
    end
    if (!new_doc && has_pos_q) begin
      pos_delta = {1'b0, pos_in} - {1'b0, pos_q};
    end else begin
      pos_delta = {1'b0, pos_in} + DELTA_W'(1);
    end
  end

  always_comb begin
    if (first_q) begin
      more = |sh_q[DELTA_W-1:HEAD_DIGIT_W];
      next_byte = {sh_q[HEAD_DIGIT_W-1:0], (state_q == ST_DOC), more};
    end else begin
      more = |sh_q[DELTA_W-1:TAIL_DIGIT_W];
      next_byte = {sh_q[TAIL_DIGIT_W-1:0], more};
    end
  end

  always_comb begin
    state_d = state_q;
    has_doc_d = has_doc_q;
    has_pos_d = has_pos_q;
    doc_d = doc_q;
    pos_d = pos_q;
    sh_d = sh_q;
    pend_d = pend_q;
    first_d = first_q;
    out_valid_d = out_valid_q && out_stall_i;
    byte_d = byte_q;
    last_d = last_q;
    err_d = err_q;
    unique case (state_q) inside
      ST_IDLE: begin
        if (accept) begin
          first_d = 1'b1;
          if (bad_order) begin
            state_d = ST_ERR;
          end else begin
            has_doc_d = 1'b1;
            has_pos_d = 1'b1;
            doc_d = doc_in;
            pos_d = pos_in;
            pend_d = pos_delta;
            if (new_doc) begin
              state_d = ST_DOC;
              sh_d = doc_delta;
            end else begin
              state_d = ST_POS;
              sh_d = pos_delta;
            end
          end
        end
      end
      ST_DOC, ST_POS: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          byte_d = next_byte;
          err_d = 1'b0;
          last_d = !more && (state_q == ST_POS);
          if (more) begin
            first_d = 1'b0;
            sh_d = first_q ? (sh_q >> HEAD_DIGIT_W) : (sh_q >> TAIL_DIGIT_W);
          end else if (state_q == ST_DOC) begin
            state_d = ST_POS;
            first_d = 1'b1;
            sh_d = pend_q;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          byte_d = '0;
          last_d = 1'b1;
          err_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      has_doc_q <= 1'b0;
      has_pos_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      has_doc_q <= has_doc_d;
      has_pos_q <= has_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    doc_q <= doc_d;
    pos_q <= pos_d;
    sh_q <= sh_d;
    pend_q <= pend_d;
    first_q <= first_d;
    byte_q <= byte_d;
    last_q <= last_d;
    err_q <= err_d;
  end

  assign out_valid_o = out_valid_q;
  assign code_byte_o = byte_q;
  assign last_byte_o = last_q;
  assign order_error_o = err_q;

endmodule
